// ===== hw/rtl/k_group_stream_reverser_macros.svh =====
// Assertion macros for the k-group stream reverser.
// Included by the top level; no other dependencies.
`ifndef K_GROUP_STREAM_REVERSER_MACROS_SVH
`define K_GROUP_STREAM_REVERSER_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication, disabled during reset
`define KGSR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");
// next-cycle implication, disabled during reset
`define KGSR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");
`else
`define KGSR_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define KGSR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hw/rtl/kgsr_pkg.sv =====
// Shared types and constants for the k-group stream reverser.
// No dependencies.
package kgsr_pkg;

    localparam int MAX_GROUP_DEF = 16;
    localparam int GS_W          = 5;
    localparam logic [GS_W-1:0] GS_RESET = 5'd1;
    localparam int VAL_W         = 32;
    // depth of the output beat queue in the back end
    localparam int OQ_DEPTH      = 4;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic                    list_end;
    } in_beat_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] out_value;
        logic                    run_last;
        logic                    out_list_end;
    } out_beat_t;

    // closed group waiting in a buffer bank
    typedef struct packed {
        logic valid;
        logic rev;
        logic list_end;
    } job_t;

endpackage

// ===== hw/rtl/kgsr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module kgsr_ram #(
    parameter int W = 32,
    parameter int D = 32
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [$clog2(D)-1:0] waddr,
    input  logic [W-1:0]         wdata,
    input  logic [$clog2(D)-1:0] raddr,
    output logic [W-1:0]         rdata
);

    logic [W-1:0] mem_reg [D];
    logic [W-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/kgsr_front.sv =====
// Front end: accepts input beats, fills the ping-pong buffer banks and
// closes groups into per-bank job slots. Depends on kgsr_pkg.
module kgsr_front #(
    parameter int MAX_GROUP = kgsr_pkg::MAX_GROUP_DEF,
    localparam int CW = $clog2(MAX_GROUP + 1),
    localparam int IW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1,
    localparam int AW = IW + 1
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [kgsr_pkg::GS_W-1:0]    group_size,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  kgsr_pkg::in_beat_t           in_beat,
    output logic                         wr_en,
    output logic [AW-1:0]                wr_addr,
    output logic [kgsr_pkg::VAL_W-1:0]   wr_data,
    input  logic                         rd_bank,
    input  logic                         release_bank,
    output kgsr_pkg::job_t               job,
    output logic [CW-1:0]                job_cnt
);

    logic [CW-1:0] fill_reg, fill_next;
    logic          wbank_reg, wbank_next;
    logic [1:0]    busy_reg, busy_next;
    logic [CW-1:0] slot_cnt_reg [2];
    logic [1:0]    slot_rev_reg;
    logic [1:0]    slot_le_reg;

    logic [CW-1:0] k_eff;
    logic [CW-1:0] n;
    logic          accept;
    logic          full_grp;
    logic          close;

    // clamp the group size to 1..MAX_GROUP
    always_comb
    begin
        if (group_size == '0)
        begin
            k_eff = CW'(1);
        end
        else if (int'(group_size) > MAX_GROUP)
        begin
            k_eff = CW'(MAX_GROUP);
        end
        else
        begin
            k_eff = CW'(group_size);
        end
    end

    // classify the beat: does it close the group, and in which order
    assign in_stall = busy_reg[wbank_reg];
    assign accept   = in_valid && !in_stall;
    assign n        = fill_reg + CW'(1);
    assign full_grp = (n >= k_eff);
    assign close    = accept && (full_grp || in_beat.list_end);

    assign wr_en   = accept;
    assign wr_addr = {wbank_reg, fill_reg[IW-1:0]};
    assign wr_data = unsigned'(in_beat.value);

    // next state of fill, bank and busy flags
    always_comb
    begin
        fill_next  = fill_reg;
        wbank_next = wbank_reg;
        busy_next  = busy_reg;
        if (release_bank)
        begin
            busy_next[rd_bank] = 1'b0;
        end
        if (accept)
        begin
            fill_next = n;
        end
        if (close)
        begin
            fill_next            = '0;
            wbank_next           = !wbank_reg;
            busy_next[wbank_reg] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            wbank_reg <= 1'b0;
            busy_reg  <= '0;
        end
        else
        begin
            fill_reg  <= fill_next;
            wbank_reg <= wbank_next;
            busy_reg  <= busy_next;
        end
    end

    // job slot payload, one per bank
    always_ff @(posedge clk)
    begin
        if (close)
        begin
            slot_cnt_reg[wbank_reg] <= n;
            slot_rev_reg[wbank_reg] <= full_grp;
            slot_le_reg[wbank_reg]  <= in_beat.list_end;
        end
    end

    assign job.valid    = busy_reg[rd_bank];
    assign job.rev      = slot_rev_reg[rd_bank];
    assign job.list_end = slot_le_reg[rd_bank];
    assign job_cnt      = slot_cnt_reg[rd_bank];

endmodule

// ===== hw/rtl/kgsr_back.sv =====
// Back end: walks a closed group in its bank, reads the buffer RAM and
// queues result beats for the output. Depends on kgsr_pkg.
module kgsr_back #(
    parameter int MAX_GROUP = kgsr_pkg::MAX_GROUP_DEF,
    localparam int CW = $clog2(MAX_GROUP + 1),
    localparam int IW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1,
    localparam int AW = IW + 1
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  kgsr_pkg::job_t               job,
    input  logic [CW-1:0]                job_cnt,
    output logic                         rd_bank,
    output logic                         release_bank,
    output logic [AW-1:0]                rd_addr,
    input  logic [kgsr_pkg::VAL_W-1:0]   rd_data,
    output logic                         out_valid,
    input  logic                         out_stall,
    output kgsr_pkg::out_beat_t          out_beat
);

    localparam int QW = $clog2(kgsr_pkg::OQ_DEPTH);
    localparam int QCW = $clog2(kgsr_pkg::OQ_DEPTH + 1);

    logic [CW-1:0]       pos_reg, pos_next;
    logic                bank_reg, bank_next;
    logic                infl_reg;
    logic                tag_last_reg;
    logic                tag_le_reg;
    kgsr_pkg::out_beat_t oq_reg [kgsr_pkg::OQ_DEPTH];
    logic [QW-1:0]       oq_wp_reg;
    logic [QW-1:0]       oq_rp_reg;
    logic [QCW-1:0]      oq_cnt_reg, oq_cnt_next;

    logic [CW-1:0]       idx;
    logic                job_last;
    logic                issue;
    logic                pop;

    // read address: descending for a reversed group, ascending otherwise
    assign job_last = (pos_reg == job_cnt - CW'(1));
    assign idx      = job.rev ? (job_cnt - CW'(1) - pos_reg) : pos_reg;
    assign rd_addr  = {bank_reg, idx[IW-1:0]};
    assign rd_bank  = bank_reg;

    // issue a read only when the output queue has room for it
    assign issue        = job.valid &&
                          ((oq_cnt_reg + QCW'(infl_reg)) < QCW'(kgsr_pkg::OQ_DEPTH));
    assign release_bank = issue && job_last;
    assign pop          = out_valid && !out_stall;

    always_comb
    begin
        pos_next  = pos_reg;
        bank_next = bank_reg;
        if (issue)
        begin
            pos_next = pos_reg + CW'(1);
            if (job_last)
            begin
                pos_next  = '0;
                bank_next = !bank_reg;
            end
        end
        oq_cnt_next = oq_cnt_reg + QCW'(infl_reg) - QCW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            bank_reg   <= 1'b0;
            infl_reg   <= 1'b0;
            oq_wp_reg  <= '0;
            oq_rp_reg  <= '0;
            oq_cnt_reg <= '0;
        end
        else
        begin
            pos_reg    <= pos_next;
            bank_reg   <= bank_next;
            infl_reg   <= issue;
            oq_cnt_reg <= oq_cnt_next;
            if (infl_reg)
            begin
                oq_wp_reg <= oq_wp_reg + QW'(1);
            end
            if (pop)
            begin
                oq_rp_reg <= oq_rp_reg + QW'(1);
            end
        end
    end

    // sideband travels with the read; RAM data lands in the queue in the cycle after the read
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            tag_last_reg <= job_last;
            tag_le_reg   <= job_last && job.list_end;
        end
        if (infl_reg)
        begin
            oq_reg[oq_wp_reg].out_value    <= signed'(rd_data);
            oq_reg[oq_wp_reg].run_last     <= tag_last_reg;
            oq_reg[oq_wp_reg].out_list_end <= tag_le_reg;
        end
    end

    assign out_valid = (oq_cnt_reg != '0);
    assign out_beat  = oq_reg[oq_rp_reg];

endmodule

// ===== hw/rtl/k_group_stream_reverser.sv =====
// Top level of the k-group stream reverser: config register, front end,
// buffer RAM and back end. Depends on kgsr_pkg, kgsr_ram, kgsr_front, kgsr_back.
//
//  channel | signals                      | beat
//  --------+------------------------------+--------------------------------
//  in      | in_valid / in_stall          | in_beat  (value, list_end)
//  out     | out_valid / out_stall        | out_beat (out_value, run_last,
//          |                              |           out_list_end)
//  cfg     | cfg_we / cfg_wdata           | group_size, no read-back
//
// An input beat is taken whenever its buffer bank is free; two
// banks alternate, so one group fills while the previous one drains.
// A closed group of n values leaves at one beat per cycle unless out_stall
// holds it; its first beat passes busy flag, RAM read register and queue.
// Reset clears all control state; the buffer RAM needs no clearing pass.
// in_stall is high while the bank being filled still holds an undrained group.
`include "k_group_stream_reverser_macros.svh"
module k_group_stream_reverser #(
    parameter int MAX_GROUP = kgsr_pkg::MAX_GROUP_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  kgsr_pkg::in_beat_t         in_beat,
    output logic                       out_valid,
    input  logic                       out_stall,
    output kgsr_pkg::out_beat_t        out_beat,
    input  logic                       cfg_we,
    input  logic [kgsr_pkg::GS_W-1:0]  cfg_wdata
);

    localparam int CW = $clog2(MAX_GROUP + 1);
    localparam int IW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
    localparam int AW = IW + 1;

    logic [kgsr_pkg::GS_W-1:0]  group_size_reg;
    logic                       wr_en;
    logic [AW-1:0]              wr_addr;
    logic [kgsr_pkg::VAL_W-1:0] wr_data;
    logic [AW-1:0]              rd_addr;
    logic [kgsr_pkg::VAL_W-1:0] rd_data;
    logic                       rd_bank;
    logic                       release_bank;
    kgsr_pkg::job_t             job;
    logic [CW-1:0]              job_cnt;

    // group size register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_size_reg <= kgsr_pkg::GS_RESET;
        end
        else if (cfg_we)
        begin
            group_size_reg <= cfg_wdata;
        end
    end

    kgsr_front #(
        .MAX_GROUP(MAX_GROUP)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .group_size   (group_size_reg),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_beat      (in_beat),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data),
        .rd_bank      (rd_bank),
        .release_bank (release_bank),
        .job          (job),
        .job_cnt      (job_cnt)
    );

    // two banks of 2**IW entries (at least MAX_GROUP), bank select in the address MSB
    kgsr_ram #(
        .W(kgsr_pkg::VAL_W),
        .D(1 << AW)
    ) u_buf (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    kgsr_back #(
        .MAX_GROUP(MAX_GROUP)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .job          (job),
        .job_cnt      (job_cnt),
        .rd_bank      (rd_bank),
        .release_bank (release_bank),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_beat     (out_beat)
    );

    // a bank is only released while it holds a closed group
    `KGSR_ASSERT_SAME(a_release_has_job, clk, rst_n, release_bank, job.valid)
    // after a release the back end moves on to the other bank
    `KGSR_ASSERT_NEXT(a_release_swaps_bank, clk, rst_n, release_bank, rd_bank != $past(rd_bank))
    // end of list only ever rides on the last beat of a burst
    `KGSR_ASSERT_SAME(a_list_end_is_last, clk, rst_n, out_valid && out_beat.out_list_end, out_beat.run_last)

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for k_group_stream_reverser: predicts the group
// reordering beat by beat and checks every output beat. Depends on kgsr_pkg and k_group_stream_reverser.
module testbench;
    import kgsr_pkg::*;

    localparam int MAX_G         = MAX_GROUP_DEF;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int PHASE_BEATS   = 28;
    localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

    logic            clk;
    logic            rst_n;
    logic            in_valid;
    logic            in_stall;
    in_beat_t        in_beat;
    logic            out_valid;
    logic            out_stall;
    out_beat_t       out_beat;
    logic            cfg_we;
    logic [GS_W-1:0] cfg_wdata;

    // predictor state
    logic [GS_W-1:0]         size_reg;
    logic signed [VAL_W-1:0] held_vals [MAX_G];
    int unsigned             held_count;
    out_beat_t               reordered_q [$];

    // knobs shared with the driving processes
    int send_idle_pct;
    int stall_pct;
    int hold_req;

    // run statistics
    int cycle_count;
    int fail_count;
    int beats_sent;
    int beats_checked;
    int groups_reversed;
    int groups_in_order;
    int in_stall_cycles;

    k_group_stream_reverser i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_beat   (in_beat),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_beat  (out_beat),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // cycle count and input back-pressure count
    always @(posedge clk)
    begin
        cycle_count++;
        if (in_valid && in_stall)
            in_stall_cycles++;
    end

    // watchdog
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("testbench failed");
        $finish;
    end

    // size 0 behaves as 1, anything above the buffer depth as the full depth
    function automatic int unsigned group_len(input logic [GS_W-1:0] s);
        if (s == '0)
            return 1;
        if (int'(s) > MAX_G)
            return MAX_G;
        return int'(s);
    endfunction

    // buffer one value; on a closed group queue the beats it releases
    task automatic group_reorder(input in_beat_t b);
        int unsigned k;
        int unsigned n;
        bit          full;
        out_beat_t   r;
        k = group_len(size_reg);
        if (held_count < MAX_G)
        begin
            held_vals[held_count] = b.value;
            held_count++;
        end
        n    = held_count;
        full = (n >= k);
        if (full || b.list_end)
        begin
            for (int i = 0; i < int'(n); i++)
            begin
                r.out_value    = full ? held_vals[n - 1 - i] : held_vals[i];
                r.run_last     = (i == int'(n) - 1);
                r.out_list_end = (i == int'(n) - 1) && b.list_end;
                reordered_q.insert(reordered_q.size(), r);
            end
            if (full)
                groups_reversed++;
            else
                groups_in_order++;
            held_count = 0;
        end
    endtask

    // offer one beat, with random idle cycles ahead of it, until taken
    task automatic send_beat(input logic signed [VAL_W-1:0] v, input logic le);
        in_beat_t b;
        b.value    = v;
        b.list_end = le;
        @(negedge clk);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= b;
        do
            @(posedge clk);
        while (in_stall);
        beats_sent++;
        group_reorder(b);
    endtask

    // drop valid and wait until every predicted beat has come out
    task automatic wait_drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (reordered_q.size() != 0)
            @(posedge clk);
        // a filling group produces nothing yet; let the pipeline settle
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // only called with no output beats pending; a group may still be partly filled
    task automatic write_group_size(input logic [GS_W-1:0] v);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
        size_reg   = v;
    endtask

    function automatic logic signed [VAL_W-1:0] pick_value();
        case ($urandom_range(7))
            0:       return VAL_MIN;
            1:       return VAL_MAX;
            2:       return '0;
            3:       return -1;
            default: return $urandom;
        endcase
    endfunction

    // receiver: random stalls, or a long hold when one is requested
    initial
    begin
        int hold_left;
        hold_left = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req > 0)
            begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                out_stall <= (stall_pct != 0 && $urandom_range(99) < stall_pct);
            end
        end
    end

    // output check: capture at the edge, compare once the edge has settled
    initial
    begin
        out_beat_t got;
        out_beat_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                got = out_beat;
                #1;
                beats_checked++;
                if (reordered_q.size() == 0)
                begin
                    $error("output beat with none pending: out_value %0d", got.out_value);
                    fail_count++;
                end
                else
                begin
                    want = reordered_q.pop_front();
                    if (got.out_value !== want.out_value)
                    begin
                        $error("out_value: expected %0d, actual %0d",
                               want.out_value, got.out_value);
                        fail_count++;
                    end
                    if (got.run_last !== want.run_last)
                    begin
                        $error("run_last: expected %0d, actual %0d",
                               want.run_last, got.run_last);
                        fail_count++;
                    end
                    if (got.out_list_end !== want.out_list_end)
                    begin
                        $error("out_list_end: expected %0d, actual %0d",
                               want.out_list_end, got.out_list_end);
                        fail_count++;
                    end
                end
            end
        end
    end

    // reset value of the size register: every beat passes straight through
    task automatic test_pass_through();
        send_beat(VAL_MIN, 1'b0);
        send_beat(VAL_MAX, 1'b1);
        send_beat('0, 1'b0);
        send_beat(-1, 1'b1);
        wait_drain();
    endtask

    // size 0 acts as 1, size above the depth acts as the full depth
    task automatic test_size_clamp();
        write_group_size('0);
        send_beat(32'sh1234_5678, 1'b0);
        send_beat(-32'sd7, 1'b1);
        wait_drain();
        write_group_size('1);
        send_beat(32'sd11, 1'b0);
        send_beat(32'sd22, 1'b0);
        send_beat(32'sd33, 1'b1);
        wait_drain();
    endtask

    // full group closed by list end is reversed; a short list keeps its order
    task automatic test_group_reverse();
        write_group_size(GS_W'(3));
        send_beat(32'sd1, 1'b0);
        send_beat(32'sd2, 1'b0);
        send_beat(32'sd3, 1'b1);
        send_beat(VAL_MAX, 1'b0);
        send_beat(VAL_MIN, 1'b1);
        wait_drain();
    endtask

    // shrinking the size below the fill level flushes everything reversed
    task automatic test_size_lowered();
        write_group_size(GS_W'(8));
        for (int i = 0; i < 5; i++)
            send_beat(100 + i, 1'b0);
        wait_drain();
        write_group_size(GS_W'(2));
        send_beat(32'sd200, 1'b0);
        wait_drain();
    endtask

    // long receiver hold fills both banks; then the sender waits for a drain
    task automatic test_backpressure();
        write_group_size(GS_W'(MAX_G));
        hold_req = 120;
        for (int i = 0; i < 40; i++)
            send_beat(pick_value(), 1'b0);
        wait_drain();
        // the remaining eight complete a full group that ends the list
        for (int i = 0; i < 8; i++)
            send_beat(pick_value(), i == 7);
        wait_drain();
    endtask

    // random lists under the four idle/stall mixes, new size for each
    task automatic test_random_phases();
        int          send_pcts [4];
        int          stall_pcts [4];
        int          left;
        logic        le;
        logic [GS_W-1:0] sz;
        send_pcts  = '{0, 68, 0, 27};
        stall_pcts = '{0, 0, 68, 27};
        for (int p = 0; p < 4; p++)
        begin
            wait_drain();
            if ($urandom_range(3) == 0)
                sz = GS_W'($urandom_range(0, 31));
            else
                sz = GS_W'($urandom_range(1, MAX_G));
            write_group_size(sz);
            send_idle_pct = send_pcts[p];
            stall_pct     = stall_pcts[p];
            left = 0;
            for (int i = 0; i < PHASE_BEATS; i++)
            begin
                if (left == 0)
                    left = $urandom_range(1, 2 * group_len(size_reg) + 2);
                // now and then a list is cut short
                le = (left == 1) || ($urandom_range(19) == 0);
                send_beat(pick_value(), le);
                left = le ? 0 : left - 1;
            end
        end
        wait_drain();
        send_idle_pct = 0;
        stall_pct     = 0;
    endtask

    // main sequence
    initial
    begin
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        in_beat         = '0;
        cfg_we          = 1'b0;
        cfg_wdata       = '0;
        send_idle_pct   = 0;
        stall_pct       = 0;
        hold_req        = 0;
        cycle_count     = 0;
        fail_count      = 0;
        beats_sent      = 0;
        beats_checked   = 0;
        groups_reversed = 0;
        groups_in_order = 0;
        in_stall_cycles = 0;
        size_reg        = GS_RESET;
        held_count      = 0;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_pass_through();
        test_size_clamp();
        test_group_reverse();
        test_size_lowered();
        test_backpressure();
        test_random_phases();

        $display("sent %0d input beats, checked %0d output beats in %0d cycles",
                 beats_sent, beats_checked, cycle_count);
        $display("groups reversed %0d, short lists in order %0d, input stall cycles %0d",
                 groups_reversed, groups_in_order, in_stall_cycles);
        if (fail_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
